@@ rtl/sac_pkg.sv @@
// Shared types and constants of the set-associative write-back cache.
// Used by sac_ctrl, sac_dp and set_assoc_writeback_cache; depends on nothing.
package sac_pkg;

    localparam int LINE_BITS = 6;
    localparam int ADDR_W    = 25;
    localparam int BLK_W     = ADDR_W - LINE_BITS;
    localparam int DATA_W    = 32;
    localparam int WIDX_W    = 4;
    localparam int SEED_W    = 16;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_REFILL = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_READ   = 2'd0,
        RES_WRDONE = 2'd1,
        RES_WB     = 2'd2,
        RES_FETCH  = 2'd3
    } res_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   wdata;
        logic [DATA_W-1:0]   wmask;
    } req_t;

    typedef struct packed {
        res_t                kind_res;
        logic [BLK_W-1:0]    mem_blk;
        logic [WIDX_W-1:0]   word_index;
        logic [DATA_W-1:0]   data;
        logic                hit;
        logic                last;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TAG,
        ST_DONE,
        ST_WB_RD,
        ST_WB_OUT,
        ST_FETCH,
        ST_REFILL,
        ST_FIN_RD
    } state_t;

    // Source of the data memory read address
    typedef enum logic [1:0] {
        SRC_HIT = 2'd0,
        SRC_ACC = 2'd1,
        SRC_WB  = 2'd2
    } dsrc_t;

    typedef struct packed {
        logic   latch;
        logic   tag_rd;
        logic   clr_wr;
        logic   hit_go;
        logic   miss;
        logic   dat_rd;
        dsrc_t  dsrc;
        logic   dat_wr_refill;
        logic   dat_wr_merge;
        logic   cnt_inc;
        logic   refill_done;
        logic   out_ld;
        res_t   out_sel;
    } cmd_t;

    typedef struct packed {
        logic   clr_last;
        logic   hit;
        logic   need_wb;
        logic   cnt_last;
        logic   is_write;
        logic   out_free;
    } status_t;

endpackage

@@ rtl/sac_ctrl.sv @@
// Controller state machine of the cache: sequences lookup, writeback,
// fetch and refill. Depends on sac_pkg; drives the datapath by sac_pkg::cmd_t.
module sac_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  sac_pkg::kind_t     req_kind,
    input  sac_pkg::status_t   status,
    output sac_pkg::cmd_t      cmd,
    output logic               req_stall
);

    sac_pkg::state_t state_reg;
    sac_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sac_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the sequence and issue commands
    always_comb
    begin
        cmd        = '0;
        cmd.dsrc   = sac_pkg::SRC_HIT;
        cmd.out_sel = sac_pkg::RES_READ;
        state_next = state_reg;
        req_stall  = 1'b1;
        case (state_reg)
            sac_pkg::ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = sac_pkg::ST_IDLE;
                end
            end
            sac_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid && (req_kind inside {sac_pkg::KIND_READ,
                                                   sac_pkg::KIND_WRITE}))
                begin
                    cmd.latch  = 1'b1;
                    cmd.tag_rd = 1'b1;
                    state_next = sac_pkg::ST_TAG;
                end
            end
            sac_pkg::ST_TAG:
            begin
                if (status.hit)
                begin
                    cmd.hit_go = 1'b1;
                    cmd.dat_rd = 1'b1;
                    cmd.dsrc   = sac_pkg::SRC_HIT;
                    state_next = sac_pkg::ST_DONE;
                end
                else
                begin
                    cmd.miss   = 1'b1;
                    state_next = status.need_wb ? sac_pkg::ST_WB_RD : sac_pkg::ST_FETCH;
                end
            end
            sac_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_ld       = 1'b1;
                    cmd.out_sel      = status.is_write ? sac_pkg::RES_WRDONE
                                                       : sac_pkg::RES_READ;
                    cmd.dat_wr_merge = status.is_write;
                    state_next       = sac_pkg::ST_IDLE;
                end
            end
            sac_pkg::ST_WB_RD:
            begin
                cmd.dat_rd = 1'b1;
                cmd.dsrc   = sac_pkg::SRC_WB;
                state_next = sac_pkg::ST_WB_OUT;
            end
            sac_pkg::ST_WB_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_ld  = 1'b1;
                    cmd.out_sel = sac_pkg::RES_WB;
                    cmd.cnt_inc = 1'b1;
                    state_next  = status.cnt_last ? sac_pkg::ST_FETCH : sac_pkg::ST_WB_RD;
                end
            end
            sac_pkg::ST_FETCH:
            begin
                if (status.out_free)
                begin
                    cmd.out_ld  = 1'b1;
                    cmd.out_sel = sac_pkg::RES_FETCH;
                    state_next  = sac_pkg::ST_REFILL;
                end
            end
            sac_pkg::ST_REFILL:
            begin
                req_stall = 1'b0;
                if (req_valid && req_kind == sac_pkg::KIND_REFILL)
                begin
                    cmd.dat_wr_refill = 1'b1;
                    cmd.cnt_inc       = 1'b1;
                    if (status.cnt_last)
                    begin
                        cmd.refill_done = 1'b1;
                        state_next      = sac_pkg::ST_FIN_RD;
                    end
                end
            end
            sac_pkg::ST_FIN_RD:
            begin
                cmd.dat_rd = 1'b1;
                cmd.dsrc   = sac_pkg::SRC_ACC;
                state_next = sac_pkg::ST_DONE;
            end
            default:
            begin
                state_next = sac_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

@@ rtl/sac_dp.sv @@
// Datapath of the cache: tag and data memories, victim choice, LFSR,
// word counter and result register. Depends on sac_pkg; driven by sac_ctrl.
module sac_dp #(
    parameter int TOTAL_SIZE_BITS = 14,
    parameter int WAY_BITS        = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sac_pkg::SEED_W-1:0]    cfg_wdata,
    input  sac_pkg::req_t                 req,
    input  sac_pkg::cmd_t                 cmd,
    output sac_pkg::status_t              status,
    input  logic                          rsp_stall,
    output logic                          rsp_valid,
    output sac_pkg::rsp_t                 rsp
);

    localparam int SET_RAW  = TOTAL_SIZE_BITS - WAY_BITS - sac_pkg::LINE_BITS;
    localparam int SET_BITS = (SET_RAW > 0) ? SET_RAW : 0;
    localparam int SB       = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WB       = (WAY_BITS > 0) ? WAY_BITS : 1;
    localparam int NW       = 1 << WAY_BITS;
    localparam int TW       = sac_pkg::ADDR_W - sac_pkg::LINE_BITS - SET_BITS;
    localparam int DA_W     = SB + WB + sac_pkg::WIDX_W;

    typedef struct packed {
        logic [NW-1:0]          v;
        logic [NW-1:0]          d;
        logic [NW-1:0][TW-1:0]  t;
    } row_t;

    row_t                        tag_mem [2**SB];
    logic [sac_pkg::DATA_W-1:0]  dat_mem [2**DA_W];

    sac_pkg::req_t               item_reg;
    row_t                        rd_row_reg;
    row_t                        row_reg;
    row_t                        row_next;
    logic [sac_pkg::DATA_W-1:0]  dat_q_reg;
    logic [WB-1:0]               way_reg;
    logic [sac_pkg::WIDX_W-1:0]  cnt_reg;
    logic                        hit_flag_reg;
    logic [sac_pkg::BLK_W-1:0]   wb_blk_reg;
    logic [SB-1:0]               clr_idx_reg;
    logic [sac_pkg::SEED_W-1:0]  lfsr_reg;
    logic                        rsp_valid_reg;
    sac_pkg::rsp_t               rsp_reg;
    sac_pkg::rsp_t               rsp_next;

    logic [SB-1:0]               set_idx;
    logic [SB-1:0]               req_set;
    logic [TW-1:0]               item_tag;
    logic [sac_pkg::WIDX_W-1:0]  word_sel;
    logic [NW-1:0]               hit_vec;
    logic [WB-1:0]               hit_way;
    logic                        found_inv;
    logic [WB-1:0]               inv_way;
    logic [WB-1:0]               victim;
    logic                        lfsr_fb;
    logic [sac_pkg::SEED_W-1:0]  lfsr_adv;
    logic                        tag_we;
    logic [SB-1:0]               tag_widx;
    row_t                        tag_wdata;
    logic [DA_W-1:0]             dat_raddr;
    logic [DA_W-1:0]             dat_waddr;
    logic [sac_pkg::DATA_W-1:0]  dat_wdata;
    logic                        dat_we;
    logic                        rsp_free;

    // Split the addresses
    assign set_idx  = (SET_BITS > 0) ? item_reg.addr[sac_pkg::LINE_BITS +: SB] : '0;
    assign req_set  = (SET_BITS > 0) ? req.addr[sac_pkg::LINE_BITS +: SB] : '0;
    assign item_tag = item_reg.addr[sac_pkg::ADDR_W-1 -: TW];
    assign word_sel = item_reg.addr[sac_pkg::LINE_BITS-1 -: sac_pkg::WIDX_W];

    // Compare tags and find the first invalid way
    always_comb
    begin
        hit_way   = '0;
        inv_way   = '0;
        found_inv = 1'b0;
        for (int i = 0; i < NW; i++)
        begin
            hit_vec[i] = rd_row_reg.v[i] && (rd_row_reg.t[i] == item_tag);
        end
        for (int i = NW - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_way = WB'(i);
            end
            if (!rd_row_reg.v[i])
            begin
                inv_way   = WB'(i);
                found_inv = 1'b1;
            end
        end
    end

    // Step the LFSR and pick the victim
    assign lfsr_fb  = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];
    assign lfsr_adv = {lfsr_fb, lfsr_reg[sac_pkg::SEED_W-1:1]};
    assign victim   = found_inv ? inv_way : (lfsr_adv[WB-1:0] & WB'(NW - 1));

    // Update the working copy of the set's tag row
    always_comb
    begin
        row_next = row_reg;
        if (cmd.hit_go)
        begin
            row_next = rd_row_reg;
        end
        if (cmd.miss)
        begin
            row_next           = rd_row_reg;
            row_next.v[victim] = 1'b0;
            row_next.d[victim] = 1'b0;
        end
        if (cmd.refill_done)
        begin
            row_next.v[way_reg] = 1'b1;
            row_next.d[way_reg] = 1'b0;
            row_next.t[way_reg] = item_tag;
        end
        if (cmd.dat_wr_merge)
        begin
            row_next.d[way_reg] = 1'b1;
        end
    end

    assign tag_we    = cmd.clr_wr || cmd.miss || cmd.refill_done || cmd.dat_wr_merge;
    assign tag_widx  = cmd.clr_wr ? clr_idx_reg : set_idx;
    assign tag_wdata = cmd.clr_wr ? row_t'('0) : row_next;

    // Tag memory: one row per set
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_widx] <= tag_wdata;
        end
        if (cmd.tag_rd)
        begin
            rd_row_reg <= tag_mem[req_set];
        end
    end

    // Select data memory addresses
    always_comb
    begin
        case (cmd.dsrc)
            sac_pkg::SRC_HIT: dat_raddr = {set_idx, hit_way, word_sel};
            sac_pkg::SRC_ACC: dat_raddr = {set_idx, way_reg, word_sel};
            sac_pkg::SRC_WB:  dat_raddr = {set_idx, way_reg, cnt_reg};
            default:          dat_raddr = {set_idx, way_reg, word_sel};
        endcase
        dat_we = cmd.dat_wr_refill || cmd.dat_wr_merge;
        if (cmd.dat_wr_refill)
        begin
            dat_waddr = {set_idx, way_reg, cnt_reg};
            dat_wdata = req.wdata;
        end
        else
        begin
            dat_waddr = {set_idx, way_reg, word_sel};
            dat_wdata = (dat_q_reg & ~item_reg.wmask) | (item_reg.wdata & item_reg.wmask);
        end
    end

    // Data memory: one word per cycle
    always_ff @(posedge clk)
    begin
        if (dat_we)
        begin
            dat_mem[dat_waddr] <= dat_wdata;
        end
        if (cmd.dat_rd)
        begin
            dat_q_reg <= dat_mem[dat_raddr];
        end
    end

    // Hold the access and the miss bookkeeping
    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        if (cmd.latch)
        begin
            item_reg <= req;
        end
        if (cmd.hit_go)
        begin
            way_reg      <= hit_way;
            hit_flag_reg <= 1'b1;
        end
        if (cmd.miss)
        begin
            way_reg      <= victim;
            hit_flag_reg <= 1'b0;
            wb_blk_reg   <= sac_pkg::BLK_W'({rd_row_reg.t[victim], set_idx} >> (SB - SET_BITS));
        end
    end

    // Count words, sweep the tag memory, step the LFSR
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            clr_idx_reg <= '0;
            lfsr_reg    <= sac_pkg::SEED_W'(1);
        end
        else
        begin
            if (cmd.miss)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.clr_wr)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cfg_we)
            begin
                lfsr_reg <= (cfg_wdata == '0) ? sac_pkg::SEED_W'(1) : cfg_wdata;
            end
            else if (cmd.miss && !found_inv)
            begin
                lfsr_reg <= lfsr_adv;
            end
        end
    end

    // Result register: drop on take, load on command
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_ld)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Build the next result beat
    always_comb
    begin
        rsp_next          = '0;
        rsp_next.kind_res = cmd.out_sel;
        case (cmd.out_sel)
            sac_pkg::RES_READ:
            begin
                rsp_next.data = dat_q_reg;
                rsp_next.hit  = hit_flag_reg;
                rsp_next.last = 1'b1;
            end
            sac_pkg::RES_WRDONE:
            begin
                rsp_next.hit  = hit_flag_reg;
                rsp_next.last = 1'b1;
            end
            sac_pkg::RES_WB:
            begin
                rsp_next.mem_blk    = wb_blk_reg;
                rsp_next.word_index = cnt_reg;
                rsp_next.data       = dat_q_reg;
            end
            sac_pkg::RES_FETCH:
            begin
                rsp_next.mem_blk = item_reg.addr[sac_pkg::ADDR_W-1:sac_pkg::LINE_BITS];
                rsp_next.last    = 1'b1;
            end
            default:
            begin
                rsp_next.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Report status to the controller
    assign status.clr_last = &clr_idx_reg;
    assign status.hit      = |hit_vec;
    assign status.need_wb  = !found_inv && rd_row_reg.d[victim];
    assign status.cnt_last = &cnt_reg;
    assign status.is_write = (item_reg.kind == sac_pkg::KIND_WRITE);
    assign status.out_free = rsp_free;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> rsp_free)
        else $error("result loaded while the result register is occupied");

    a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> lfsr_reg != '0)
        else $error("replacement LFSR reached zero");

    a_victim_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.miss |=> !row_reg.v[way_reg] && !row_reg.d[way_reg])
        else $error("victim line still valid after miss");

    a_refill_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.refill_done |=> row_reg.v[way_reg] && !row_reg.d[way_reg])
        else $error("refilled line not marked valid and clean");

endmodule

@@ rtl/set_assoc_writeback_cache.sv @@
// Top level of the set-associative write-back cache.
// Depends on sac_pkg, sac_ctrl and sac_dp.

// A read or masked write is looked up against every way of its set. A hit
// loads its single result after the tag-row read and then the data-word read,
// and the next beat can be taken once that result is loaded; a stalled result
// register holds the block for as long as the stall lasts. A miss chooses the
// first invalid way, or an LFSR-picked way when the set is full; a dirty victim
// is streamed out as 16 writeback beats, each read from the data memory before
// it is loaded (one data memory read port), then a fetch request beat follows.
// The block then takes refill beats only, one per cycle, and the sixteenth
// completes the access with a result marked as a miss, loaded after a further
// data-word read. Other beats taken while a miss is pending are dropped, as are
// stray refills and kind 3. After reset a clearing pass over all
// 2**max(1, TOTAL_SIZE_BITS - WAY_BITS - 6) tag rows empties the tag memory;
// no beat is taken during it.
module set_assoc_writeback_cache #(
    parameter int TOTAL_SIZE_BITS = 14,
    parameter int WAY_BITS        = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [sac_pkg::SEED_W-1:0]  cfg_wdata,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  sac_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output sac_pkg::rsp_t               rsp
);

    sac_pkg::cmd_t    cmd;
    sac_pkg::status_t status;

    sac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req.kind),
        .status    (status),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    sac_dp #(
        .TOTAL_SIZE_BITS (TOTAL_SIZE_BITS),
        .WAY_BITS        (WAY_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

@@ tb/cache_checker.sv @@
// Checker for the set-associative write-back cache: watches both channels and
// the seed port, predicts every result beat and compares it field by field.
// Depends on sac_pkg only.
module cache_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sac_pkg::SEED_W-1:0] cfg_wdata,
    input  logic                       req_valid,
    input  logic                       req_stall,
    input  sac_pkg::req_t              req,
    input  logic                       rsp_valid,
    input  logic                       rsp_stall,
    input  sac_pkg::rsp_t              rsp,
    output int                         errors,
    output int                         waiting,
    output logic                       miss_open
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_BITS = 6;
    localparam int N_WAYS   = 4;
    localparam int N_LINES  = 256;
    localparam int TAG_W    = sac_pkg::ADDR_W - SET_BITS - sac_pkg::LINE_BITS;

    logic                       line_ok    [N_LINES];
    logic                       line_mod   [N_LINES];
    logic [TAG_W-1:0]           line_tagv  [N_LINES];
    logic [sac_pkg::DATA_W-1:0] line_data  [N_LINES*16];

    sac_pkg::req_t miss_req;
    int unsigned   fill_line;
    int unsigned   fill_cnt;
    logic [15:0]   rnd_way;
    sac_pkg::rsp_t exp_beats[$];

    function automatic sac_pkg::rsp_t mk_beat(sac_pkg::res_t k,
                                              logic [sac_pkg::BLK_W-1:0] blk,
                                              logic [3:0] widx,
                                              logic [sac_pkg::DATA_W-1:0] d,
                                              logic h, logic l);
        sac_pkg::rsp_t r;
        r.kind_res   = k;
        r.mem_blk    = blk;
        r.word_index = widx;
        r.data       = d;
        r.hit        = h;
        r.last       = l;
        return r;
    endfunction

    // Finish a read or write on a line that holds the block
    task automatic finish_access(int unsigned ln, sac_pkg::req_t a, logic h);
        int unsigned idx;
        idx = ln * 16 + a.addr[5:2];
        if (a.kind == sac_pkg::KIND_WRITE)
        begin
            line_data[idx] = (line_data[idx] & ~a.wmask) | (a.wdata & a.wmask);
            line_mod[ln] = 1'b1;
            exp_beats.push_back(mk_beat(sac_pkg::RES_WRDONE, '0, '0, '0, h, 1'b1));
        end
        else
        begin
            exp_beats.push_back(mk_beat(sac_pkg::RES_READ, '0, '0, line_data[idx], h, 1'b1));
        end
    endtask

    task automatic predict_beat(sac_pkg::req_t b);
        logic [SET_BITS-1:0] set;
        logic [TAG_W-1:0]    tag;
        int unsigned         victim;
        logic                found;
        logic                fb;
        set = b.addr[sac_pkg::LINE_BITS +: SET_BITS];
        tag = b.addr[sac_pkg::ADDR_W-1 -: TAG_W];
        found = 1'b0;
        victim = 0;
        if (b.kind == sac_pkg::KIND_REFILL)
        begin
            if (miss_open)
            begin
                line_data[fill_line*16 + fill_cnt] = b.wdata;
                fill_cnt++;
                if (fill_cnt == 16)
                begin
                    line_ok[fill_line]   = 1'b1;
                    line_mod[fill_line]  = 1'b0;
                    line_tagv[fill_line] = miss_req.addr[sac_pkg::ADDR_W-1 -: TAG_W];
                    miss_open = 1'b0;
                    fill_cnt  = 0;
                    finish_access(fill_line, miss_req, 1'b0);
                end
            end
        end
        else if (b.kind != sac_pkg::KIND_NONE && !miss_open)
        begin
            // Look up every way of the set
            for (int w = 0; w < N_WAYS; w++)
            begin
                if (!found && line_ok[set*N_WAYS + w] && line_tagv[set*N_WAYS + w] == tag)
                begin
                    found = 1'b1;
                    finish_access(set*N_WAYS + w, b, 1'b1);
                end
            end
            if (!found)
            begin
                for (int w = 0; w < N_WAYS; w++)
                begin
                    if (!found && !line_ok[set*N_WAYS + w])
                    begin
                        found  = 1'b1;
                        victim = set*N_WAYS + w;
                    end
                end
                // Full set: advance the LFSR and evict, writing back if dirty
                if (!found)
                begin
                    fb = rnd_way[0] ^ rnd_way[2] ^ rnd_way[3] ^ rnd_way[5];
                    rnd_way = {fb, rnd_way[15:1]};
                    victim = set*N_WAYS + rnd_way[1:0];
                    if (line_mod[victim])
                    begin
                        for (int w = 0; w < 16; w++)
                            exp_beats.push_back(mk_beat(sac_pkg::RES_WB,
                                {line_tagv[victim], set}, w[3:0],
                                line_data[victim*16 + w], 1'b0, 1'b0));
                    end
                end
                line_ok[victim]  = 1'b0;
                line_mod[victim] = 1'b0;
                miss_open = 1'b1;
                miss_req  = b;
                fill_line = victim;
                fill_cnt  = 0;
                exp_beats.push_back(mk_beat(sac_pkg::RES_FETCH,
                    b.addr[sac_pkg::ADDR_W-1:sac_pkg::LINE_BITS], '0, '0, 1'b0, 1'b1));
            end
        end
    endtask

    task automatic check_beat(sac_pkg::rsp_t act);
        sac_pkg::rsp_t e;
        if (exp_beats.size() == 0)
        begin
            $display("%0t: unexpected result beat %p", $time, act);
            errors++;
            return;
        end
        e = exp_beats.pop_front();
        if (act.kind_res !== e.kind_res)
        begin
            $display("%0t: kind_res expected %0d actual %0d", $time, e.kind_res, act.kind_res);
            errors++;
        end
        if (act.mem_blk !== e.mem_blk)
        begin
            $display("%0t: mem_blk expected %h actual %h", $time, e.mem_blk, act.mem_blk);
            errors++;
        end
        if (act.word_index !== e.word_index)
        begin
            $display("%0t: word_index expected %0d actual %0d", $time, e.word_index,
                act.word_index);
            errors++;
        end
        if (act.data !== e.data)
        begin
            $display("%0t: data expected %h actual %h", $time, e.data, act.data);
            errors++;
        end
        if (act.hit !== e.hit)
        begin
            $display("%0t: hit expected %b actual %b", $time, e.hit, act.hit);
            errors++;
        end
        if (act.last !== e.last)
        begin
            $display("%0t: last expected %b actual %b", $time, e.last, act.last);
            errors++;
        end
    endtask

    // Sample every channel at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_LINES; i++)
            begin
                line_ok[i]  = 1'b0;
                line_mod[i] = 1'b0;
            end
            miss_open = 1'b0;
            fill_cnt  = 0;
            fill_line = 0;
            rnd_way   = 16'd1;
            errors    = 0;
            exp_beats.delete();
        end
        else
        begin
            if (cfg_we)
                rnd_way = (cfg_wdata == '0) ? 16'd1 : cfg_wdata;
            if (req_valid && !req_stall)
                predict_beat(req);
            if (rsp_valid && !rsp_stall)
                check_beat(rsp);
        end
        waiting = exp_beats.size();
    end

endmodule

@@ tb/tb_top.sv @@
// Top of the cache testbench: clock, reset, stimulus, stall patterns and verdict.
// Depends on sac_pkg, set_assoc_writeback_cache and cache_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [sac_pkg::SEED_W-1:0] cfg_wdata = '0;
    logic                       req_valid = 1'b0;
    logic                       req_stall;
    sac_pkg::req_t              req = '0;
    logic                       rsp_valid;
    logic                       rsp_stall = 1'b0;
    sac_pkg::rsp_t              rsp;
    int                         errors;
    int                         waiting;
    logic                       miss_open;
    int                         cycles = 0;
    int                         burst_left = 4;

    set_assoc_writeback_cache dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    cache_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .errors    (errors),
        .waiting   (waiting),
        .miss_open (miss_open)
    );

    always #10 clk = ~clk;

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stall the result channel on one of four patterns, taken in turn
    always @(negedge clk)
    begin
        case ((cycles / 97) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 1);
            2: rsp_stall <= ((cycles % 13) < 6);
            default: rsp_stall <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // Drive one beat and hold it until taken; called and returns at a falling edge
    task automatic put_beat(sac_pkg::req_t b);
        req <= b;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    function automatic sac_pkg::req_t mk_req(sac_pkg::kind_t k,
                                             logic [sac_pkg::ADDR_W-1:0] a,
                                             logic [31:0] d, logic [31:0] m);
        sac_pkg::req_t r;
        r.kind  = k;
        r.addr  = a;
        r.wdata = d;
        r.wmask = m;
        return r;
    endfunction

    function automatic logic [sac_pkg::ADDR_W-1:0] addr_of(int unsigned tag,
                                                           int unsigned set);
        return {tag[12:0], set[5:0], 4'($urandom), 2'($urandom)};
    endfunction

    function automatic sac_pkg::req_t rand_access();
        logic [sac_pkg::ADDR_W-1:0] a;
        logic [31:0]                m;
        if ($urandom_range(0, 9) < 9)
            a = addr_of($urandom_range(0, 4), $urandom_range(0, 3));
        else
            a = sac_pkg::ADDR_W'($urandom);
        case ($urandom_range(0, 5))
            0: m = '0;
            1: m = '1;
            default: m = $urandom;
        endcase
        return mk_req($urandom_range(0, 1) ? sac_pkg::KIND_WRITE : sac_pkg::KIND_READ,
                      a, $urandom, m);
    endfunction

    // Feed the sixteen refill words, with optional dropped beats among them
    task automatic refill(bit noisy);
        for (int i = 0; i < 16; i++)
        begin
            if (noisy && $urandom_range(0, 7) == 0)
                put_beat($urandom_range(0, 1) ? rand_access()
                         : mk_req(sac_pkg::KIND_NONE, sac_pkg::ADDR_W'($urandom),
                                  $urandom, $urandom));
            put_beat(mk_req(sac_pkg::KIND_REFILL, sac_pkg::ADDR_W'($urandom),
                            $urandom, $urandom));
        end
    endtask

    // Send an access and complete its miss if it has one
    task automatic access(sac_pkg::req_t b, bit noisy);
        put_beat(b);
        if (miss_open)
            refill(noisy);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (waiting != 0 || miss_open)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic set_seed(logic [sac_pkg::SEED_W-1:0] s);
        cfg_we <= 1'b1;
        cfg_wdata <= s;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_seed(16'hFFFF);

        // Directed: extremes, hits and misses on both kinds
        access(mk_req(sac_pkg::KIND_READ, '0, '0, '0), 1'b0);
        access(mk_req(sac_pkg::KIND_READ, '0, '1, '1), 1'b0);
        access(mk_req(sac_pkg::KIND_WRITE, 25'h4, '1, '1), 1'b0);
        access(mk_req(sac_pkg::KIND_WRITE, 25'h4, '0, '0), 1'b0);
        access(mk_req(sac_pkg::KIND_WRITE, '1, '1, '1), 1'b0);
        access(mk_req(sac_pkg::KIND_READ, '1, '0, '0), 1'b0);
        // Stray refill and the unused kind are dropped
        put_beat(mk_req(sac_pkg::KIND_REFILL, '1, '1, '1));
        put_beat(mk_req(sac_pkg::KIND_NONE, '1, '1, '1));
        // Fill a set with dirty lines, then force a dirty eviction
        for (int t = 1; t <= 4; t++)
            access(mk_req(sac_pkg::KIND_WRITE, addr_of(t, 5), $urandom, '1), 1'b0);
        access(mk_req(sac_pkg::KIND_READ, addr_of(5, 5), '0, '0), 1'b1);
        access(mk_req(sac_pkg::KIND_WRITE, addr_of(6, 5), $urandom, $urandom), 1'b1);
        drain();

        // Random phases, each under its own seed; zero seed loads as one
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_seed('0);
                1: set_seed(16'd1);
                2: set_seed(16'hFFFF);
                default: set_seed(sac_pkg::SEED_W'($urandom_range(2, 65534)));
            endcase
            for (int i = 0; i < 11; i++)
            begin
                if (ph == 1 && i == 5)
                    drain();
                if ($urandom_range(0, 19) == 0)
                    put_beat(mk_req($urandom_range(0, 1) ? sac_pkg::KIND_REFILL
                                                         : sac_pkg::KIND_NONE,
                        sac_pkg::ADDR_W'($urandom), $urandom, $urandom));
                else
                    access(rand_access(), $urandom_range(0, 3) == 0);
            end
            drain();
        end

        if (errors == 0 && waiting == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/sac_pkg.sv
rtl/sac_ctrl.sv
rtl/sac_dp.sv
rtl/set_assoc_writeback_cache.sv
tb/cache_checker.sv
tb/tb_top.sv
